/* rtl/rpc_pkg.sv */
package rpc_pkg;

	localparam int CENTER_W  = 24;
	localparam int CREG_W    = 32;
	localparam int REG_IDX_W = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_CENTER_X = 3'd0,
		REG_CENTER_Y = 3'd1,
		REG_CENTER_Z = 3'd2,
		REG_X_COEFFS = 3'd3,
		REG_Y_COEFFS = 3'd4,
		REG_Z_COEFFS = 3'd5
	} rpc_reg_t;

	localparam logic [CENTER_W-1:0] CENTER_RST   = 24'd38400;
	localparam logic [CREG_W-1:0]   X_COEFFS_RST = 32'd1073545544;
	localparam logic [CREG_W-1:0]   Y_COEFFS_RST = 32'd1073676452;
	localparam logic [CREG_W-1:0]   Z_COEFFS_RST = 32'd1072890511;

	// pipeline control that travels with each beat
	typedef struct packed {
		logic vld;
		logic clip;
	} rpc_ctl_t;

endpackage

/* rtl/rpc_rot.sv */
module rpc_rot #(
	parameter int COORD_WIDTH = 24,
	parameter int COEFF_WIDTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [rpc_pkg::CREG_W-1:0]            coeffs,
	input  rpc_pkg::rpc_ctl_t                     in_ctl,
	input  logic signed [COORD_WIDTH-1:0]         in_a,
	input  logic signed [COORD_WIDTH-1:0]         in_b,
	input  logic signed [COORD_WIDTH-1:0]         in_p,
	output logic                                  in_ready,
	output rpc_pkg::rpc_ctl_t                     out_ctl,
	output logic signed [COORD_WIDTH-1:0]         out_a,
	output logic signed [COORD_WIDTH-1:0]         out_b,
	output logic signed [COORD_WIDTH-1:0]         out_p,
	input  logic                                  out_ready
);
	import rpc_pkg::*;

	localparam int PROD_W = COORD_WIDTH + COEFF_WIDTH;
	localparam int ACC_W  = PROD_W + 2;
	localparam int FRAC   = COEFF_WIDTH - 2;

	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC - 1);
	localparam logic signed [ACC_W-1:0] HI =
		{{(ACC_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] LO = ~HI;

	function automatic logic [COORD_WIDTH:0] sat_acc(input logic signed [ACC_W-1:0] v);
		if (v > HI) begin
			return {1'b1, HI[COORD_WIDTH-1:0]};
		end else if (v < LO) begin
			return {1'b1, LO[COORD_WIDTH-1:0]};
		end
		return {1'b0, v[COORD_WIDTH-1:0]};
	endfunction

	logic [2*CREG_W-1:0]             coeff_ext;
	logic signed [COEFF_WIDTH-1:0]   cos_c;
	logic signed [COEFF_WIDTH-1:0]   sin_c;

	assign coeff_ext = {{CREG_W{1'b0}}, coeffs};
	assign sin_c     = coeff_ext[COEFF_WIDTH-1:0];
	assign cos_c     = coeff_ext[2*COEFF_WIDTH-1:COEFF_WIDTH];

	rpc_ctl_t                   ctl_s1, ctl_s2;
	logic signed [PROD_W-1:0]   pca_s1, psb_s1, psa_s1, pcb_s1;
	logic signed [COORD_WIDTH-1:0] p_s1, p_s2, na_s2, nb_s2;
	logic                       rdy1, rdy2;

	logic signed [ACC_W-1:0]    acc_a, acc_b;
	logic [COORD_WIDTH:0]       sat_a, sat_b;

	assign rdy2     = !ctl_s2.vld || out_ready;
	assign rdy1     = !ctl_s1.vld || rdy2;
	assign in_ready = rdy1;

	always_comb begin
		acc_a = ACC_W'(pca_s1) - ACC_W'(psb_s1) + HALF;
		acc_b = ACC_W'(psa_s1) + ACC_W'(pcb_s1) + HALF;
		sat_a = sat_acc(acc_a >>> FRAC);
		sat_b = sat_acc(acc_b >>> FRAC);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			if (rdy1) begin
				ctl_s1 <= in_ctl;
			end
			if (rdy2) begin
				ctl_s2.vld  <= ctl_s1.vld;
				ctl_s2.clip <= ctl_s1.clip | sat_a[COORD_WIDTH] | sat_b[COORD_WIDTH];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			pca_s1 <= PROD_W'(in_a) * PROD_W'(cos_c);
			psb_s1 <= PROD_W'(in_b) * PROD_W'(sin_c);
			psa_s1 <= PROD_W'(in_a) * PROD_W'(sin_c);
			pcb_s1 <= PROD_W'(in_b) * PROD_W'(cos_c);
			p_s1   <= in_p;
		end
		if (rdy2) begin
			na_s2 <= sat_a[COORD_WIDTH-1:0];
			nb_s2 <= sat_b[COORD_WIDTH-1:0];
			p_s2  <= p_s1;
		end
	end

	assign out_ctl = ctl_s2;
	assign out_a   = na_s2;
	assign out_b   = nb_s2;
	assign out_p   = p_s2;

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s2.vld && !out_ready |=> ctl_s2.vld && $stable(na_s2) && $stable(nb_s2))
		else $error("rotation result changed while stalled");

	a_free_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("rotation stage refused a beat with downstream ready");

	a_products_move: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s1.vld && rdy2 |=> ctl_s2.vld)
		else $error("product beat lost between stages");

endmodule

/* rtl/rotate_point_about_center_core.sv */
// rotates a stream of 3d points about a configured center
// slave side: one point per beat, tdata = x, y, z (signed q15.8 at the default width)
// master side: rotated point per beat, tdata = x, y, z, tuser = clip flag
// the point is centred, rotated about x, then y, then z, and the center is added back;
// every step saturates and any saturation sets the clip flag of that beat
// throughput: one beat per cycle unless stalled; the two multiply/round stages of each axis and the
// centre subtract and add stages each hold one beat
// stalls: a stalled receiver holds the output register; upstream stages keep filling
// any empty slot, so s_tready only falls once every stage holds a beat
// config: plain write port; the user must write registers only while the pipeline is empty (not enforced)
// reset: all stages emptied, centre and coefficient registers take their defaults
module rotate_point_about_center_core #(
	parameter int COORD_WIDTH = 24,
	parameter int COEFF_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [rpc_pkg::REG_IDX_W-1:0]        cfg_addr,
	input  logic [rpc_pkg::CREG_W-1:0]           cfg_data,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// in_x, in_y, in_z, zero pad
	input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]   s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// out_x, out_y, out_z, zero pad
	output logic [((3*COORD_WIDTH+7)/8)*8-1:0]   m_tdata,
	// clipped
	output logic [0:0]                           m_tuser
);
	import rpc_pkg::*;

	localparam int TDATA_W = ((3*COORD_WIDTH+7)/8)*8;
	localparam int WIDE_W  = (COORD_WIDTH > CENTER_W) ? COORD_WIDTH : CENTER_W;
	localparam int SUM_W   = WIDE_W + 1;

	localparam logic signed [SUM_W-1:0] HI =
		{{(SUM_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] LO = ~HI;

	function automatic logic [COORD_WIDTH:0] sat_sum(input logic signed [SUM_W-1:0] v);
		if (v > HI) begin
			return {1'b1, HI[COORD_WIDTH-1:0]};
		end else if (v < LO) begin
			return {1'b1, LO[COORD_WIDTH-1:0]};
		end
		return {1'b0, v[COORD_WIDTH-1:0]};
	endfunction

	logic signed [CENTER_W-1:0] center_x_q, center_y_q, center_z_q;
	logic [CREG_W-1:0]          x_coeffs_q, y_coeffs_q, z_coeffs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= CENTER_RST;
			center_y_q <= CENTER_RST;
			center_z_q <= CENTER_RST;
			x_coeffs_q <= X_COEFFS_RST;
			y_coeffs_q <= Y_COEFFS_RST;
			z_coeffs_q <= Z_COEFFS_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_CENTER_X: center_x_q <= cfg_data[CENTER_W-1:0];
				REG_CENTER_Y: center_y_q <= cfg_data[CENTER_W-1:0];
				REG_CENTER_Z: center_z_q <= cfg_data[CENTER_W-1:0];
				REG_X_COEFFS: x_coeffs_q <= cfg_data;
				REG_Y_COEFFS: y_coeffs_q <= cfg_data;
				REG_Z_COEFFS: z_coeffs_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// centre subtract
	logic signed [COORD_WIDTH-1:0] in_x, in_y, in_z;
	logic [COORD_WIDTH:0]          cx, cy, cz;
	rpc_ctl_t                      ctl_s1, in_ctl;
	logic signed [COORD_WIDTH-1:0] x_s1, y_s1, z_s1;
	logic                          rdy_s1, rx_ready;

	assign in_x = s_tdata[COORD_WIDTH-1:0];
	assign in_y = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
	assign in_z = s_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];

	always_comb begin
		cx = sat_sum(SUM_W'(in_x) - SUM_W'(center_x_q));
		cy = sat_sum(SUM_W'(in_y) - SUM_W'(center_y_q));
		cz = sat_sum(SUM_W'(in_z) - SUM_W'(center_z_q));
		in_ctl.vld  = s_tvalid;
		in_ctl.clip = cx[COORD_WIDTH] | cy[COORD_WIDTH] | cz[COORD_WIDTH];
	end

	assign rdy_s1   = !ctl_s1.vld || rx_ready;
	assign s_tready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (rdy_s1) begin
			ctl_s1 <= in_ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			x_s1 <= cx[COORD_WIDTH-1:0];
			y_s1 <= cy[COORD_WIDTH-1:0];
			z_s1 <= cz[COORD_WIDTH-1:0];
		end
	end

	// rotations: x uses (y, z), y uses (z, x), z uses (x, y)
	rpc_ctl_t                      rx_ctl, ry_ctl, rz_ctl;
	logic signed [COORD_WIDTH-1:0] rx_y, rx_z, rx_x;
	logic signed [COORD_WIDTH-1:0] ry_z, ry_x, ry_y;
	logic signed [COORD_WIDTH-1:0] rz_x, rz_y, rz_z;
	logic                          ry_ready, rz_ready, rdy_s8;

	rpc_rot #(.COORD_WIDTH(COORD_WIDTH), .COEFF_WIDTH(COEFF_WIDTH)) u_rot_x (
		.clk(clk), .arst_n(arst_n), .coeffs(x_coeffs_q),
		.in_ctl(ctl_s1), .in_a(y_s1), .in_b(z_s1), .in_p(x_s1), .in_ready(rx_ready),
		.out_ctl(rx_ctl), .out_a(rx_y), .out_b(rx_z), .out_p(rx_x), .out_ready(ry_ready)
	);

	rpc_rot #(.COORD_WIDTH(COORD_WIDTH), .COEFF_WIDTH(COEFF_WIDTH)) u_rot_y (
		.clk(clk), .arst_n(arst_n), .coeffs(y_coeffs_q),
		.in_ctl(rx_ctl), .in_a(rx_z), .in_b(rx_x), .in_p(rx_y), .in_ready(ry_ready),
		.out_ctl(ry_ctl), .out_a(ry_z), .out_b(ry_x), .out_p(ry_y), .out_ready(rz_ready)
	);

	rpc_rot #(.COORD_WIDTH(COORD_WIDTH), .COEFF_WIDTH(COEFF_WIDTH)) u_rot_z (
		.clk(clk), .arst_n(arst_n), .coeffs(z_coeffs_q),
		.in_ctl(ry_ctl), .in_a(ry_x), .in_b(ry_y), .in_p(ry_z), .in_ready(rz_ready),
		.out_ctl(rz_ctl), .out_a(rz_x), .out_b(rz_y), .out_p(rz_z), .out_ready(rdy_s8)
	);

	// centre add back, output register
	logic [COORD_WIDTH:0]          ox, oy, oz;
	rpc_ctl_t                      ctl_s8;
	logic signed [COORD_WIDTH-1:0] x_s8, y_s8, z_s8;

	always_comb begin
		ox = sat_sum(SUM_W'(rz_x) + SUM_W'(center_x_q));
		oy = sat_sum(SUM_W'(rz_y) + SUM_W'(center_y_q));
		oz = sat_sum(SUM_W'(rz_z) + SUM_W'(center_z_q));
	end

	assign rdy_s8 = !ctl_s8.vld || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s8 <= '0;
		end else if (rdy_s8) begin
			ctl_s8.vld  <= rz_ctl.vld;
			ctl_s8.clip <= rz_ctl.clip | ox[COORD_WIDTH] | oy[COORD_WIDTH] | oz[COORD_WIDTH];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s8) begin
			x_s8 <= ox[COORD_WIDTH-1:0];
			y_s8 <= oy[COORD_WIDTH-1:0];
			z_s8 <= oz[COORD_WIDTH-1:0];
		end
	end

	assign m_tvalid = ctl_s8.vld;
	assign m_tdata  = TDATA_W'({z_s8, y_s8, x_s8});
	assign m_tuser  = ctl_s8.clip;

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) |-> s_tready)
		else $error("input refused although the output can move");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> ctl_s1.vld)
		else $error("accepted beat did not enter the first stage");

	a_s1_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s1.vld && !rx_ready |=> ctl_s1.vld && $stable(x_s1) && $stable(z_s1))
		else $error("centred point changed while stalled");

endmodule
